// ===== src/l2_vector_normalizer_defines.svh =====
// assertion macros of the vector normaliser rtl
`ifndef L2_VECTOR_NORMALIZER_DEFINES_SVH
`define L2_VECTOR_NORMALIZER_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define L2VN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define L2VN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/l2vn_pkg.sv =====
// shared types and codes of the vector normaliser
`default_nettype none

package l2vn_pkg;

  // item kinds carried in the input tuser
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  // result status carried in the output tuser
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  // configuration register map
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 1'b1;

  localparam logic                  ENABLE_RESET = 1'b1;
  localparam logic [CFG_DATA_W-1:0] LENGTH_RESET = 11'd1024;

  // scaler status towards the controller
  typedef struct packed {
    logic busy;
    logic done;
  } scl_stat_t;

endpackage

`default_nettype wire

// ===== src/l2vn_ram.sv =====
// generic simple dual-port ram with registered read
`default_nettype none

module l2vn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/l2vn_scaler.sv =====
// iterative element scaler: square, restoring divide, then digit-by-digit square root
`default_nettype none

module l2vn_scaler
  import l2vn_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = 16,
  parameter int unsigned SUM_W      = 41
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ELEM_WIDTH-1:0] elem_i,
  input  wire logic [SUM_W-1:0]      sum_i,
  output scl_stat_t                  stat_o,
  output logic      [ELEM_WIDTH-1:0] result_o
);

  localparam int unsigned W  = ELEM_WIDTH;
  localparam int unsigned QW = 2 * W - 1;
  localparam int unsigned CW = $clog2(2 * W);

  typedef enum logic [4:0] {
    SC_IDLE = 5'b00001,
    SC_MUL  = 5'b00010,
    SC_DIV  = 5'b00100,
    SC_SQRT = 5'b01000,
    SC_FIN  = 5'b10000
  } scl_state_e;

  scl_state_e st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic          neg_q, neg_d;
  logic [W-1:0]  mag_q, mag_d;
  logic [SUM_W:0] rem_q, rem_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [2*W-1:0] op_q, op_d;
  logic [W:0]    srem_q, srem_d;
  logic [W-1:0]  root_q, root_d;

  logic [2*W-1:0]   mag_sq;
  logic [SUM_W:0]   div_r;
  logic             div_ge;
  logic [W+2:0]     sq_n;
  logic [W+2:0]     sq_trial;
  logic             sq_ge;
  logic [W+2:0]     sq_r;
  logic [W:0]       round_sum;
  logic [W-1:0]     round_mag;

  // full-width square of the magnitude
  assign mag_sq = mag_q * mag_q;

  // divide step: compare, subtract, shift
  assign div_ge = rem_q >= {1'b0, sum_i};
  assign div_r  = div_ge ? (rem_q - {1'b0, sum_i}) : rem_q;

  // root step on the next bit pair
  assign sq_n     = {srem_q, op_q[2*W-1:2*W-2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign sq_ge    = sq_n >= sq_trial;
  assign sq_r     = sq_ge ? (sq_n - sq_trial) : sq_n;

  // round to nearest and restore the sign
  assign round_sum = {1'b0, root_q} + {{W{1'b0}}, 1'b1};
  assign round_mag = round_sum[W:1];
  assign result_o  = neg_q ? (~round_mag + {{(W-1){1'b0}}, 1'b1}) : round_mag;

  assign stat_o.busy = (st_q != SC_IDLE);
  assign stat_o.done = (st_q == SC_FIN);

  // sequencer
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    op_d   = op_q;
    srem_d = srem_q;
    root_d = root_q;
    unique case (st_q)
      SC_IDLE: begin
        if (start_i) begin
          neg_d = elem_i[W-1];
          mag_d = elem_i[W-1] ? (~elem_i + {{(W-1){1'b0}}, 1'b1}) : elem_i;
          st_d  = SC_MUL;
        end
      end
      SC_MUL: begin
        rem_d = (SUM_W + 1)'(mag_sq);
        quo_d = '0;
        cnt_d = CW'(QW - 1);
        st_d  = SC_DIV;
      end
      SC_DIV: begin
        rem_d = {div_r[SUM_W-1:0], 1'b0};
        quo_d = {quo_q[QW-2:0], div_ge};
        if (cnt_q == '0) begin
          op_d   = {1'b0, quo_q[QW-2:0], div_ge};
          srem_d = '0;
          root_d = '0;
          cnt_d  = CW'(W - 1);
          st_d   = SC_SQRT;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SC_SQRT: begin
        srem_d = sq_r[W:0];
        root_d = {root_q[W-2:0], sq_ge};
        op_d   = {op_q[2*W-3:0], 2'b00};
        if (cnt_q == '0) begin
          st_d = SC_FIN;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      SC_FIN: begin
        st_d = SC_IDLE;
      end
      default: begin
        st_d = SC_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= SC_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    op_q   <= op_d;
    srem_q <= srem_d;
    root_q <= root_d;
  end

endmodule

`default_nettype wire

// ===== src/l2_vector_normalizer.sv =====
// top level of the l2 vector normaliser: controller, element store and scaler
//
//  channel   | direction | handshake            | word
//  ----------+-----------+----------------------+------------------------------------
//  s_axis    | in        | tvalid / tready      | tuser: operation, tdata: element
//  m_axis    | out       | tvalid / tready      | tdata: result_element, tlast: last,
//            |           |                      | tuser: status
//  cfg       | in        | cfg_we_i             | cfg_index_i, cfg_data_i
//
// a push writes the store and squares the element, then accumulates the square into the sum.
// a pull passes the stored element through, or, when scaled, runs it through the bit-serial
// divider and square root unit.
// a pull is taken while the previous word still waits in the output register;
// its own word waits in the controller until that register is free.
// reset is asynchronous, active low; the element store has no reset and no clearing pass.
`default_nettype none
`include "l2_vector_normalizer_defines.svh"

module l2_vector_normalizer
  import l2vn_pkg::*;
#(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [((ELEM_WIDTH+7)/8)*8-1:0]   s_axis_tdata,  // element
  input  wire logic                              s_axis_tuser,  // operation
  // output stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [((ELEM_WIDTH+7)/8)*8-1:0]   m_axis_tdata,  // result_element
  output logic                                   m_axis_tlast,
  output logic                                   m_axis_tuser,  // status
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]             cfg_data_i
);

  localparam int unsigned W      = ELEM_WIDTH;
  localparam int unsigned DATA_W = ((ELEM_WIDTH + 7) / 8) * 8;
  localparam int unsigned AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned SUM_W  = 2 * W - 1 + $clog2(MAX_DIM);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_ACC  = 5'b00010,
    ST_RD   = 5'b00100,
    ST_WAIT = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e st_q, st_d;

  logic                  en_q;
  logic [CFG_DATA_W-1:0] len_q;
  logic [CNT_W-1:0]      load_cnt_q, load_cnt_d;
  logic [CNT_W-1:0]      read_cnt_q, read_cnt_d;
  logic                  readout_q, readout_d;
  logic                  scale_q, scale_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic                  m_valid_q, m_valid_d;

  // payload registers
  logic [2*W-1:0] sq_q, sq_d;
  logic [W-1:0]   res_q, res_d;
  logic           last_q, last_d;
  logic           stat_q, stat_d;
  logic [W-1:0]   m_data_q, m_data_d;
  logic           m_last_q, m_last_d;
  logic           m_stat_q, m_stat_d;

  logic                  in_acc;
  logic                  is_push;
  logic                  is_pull;
  logic [W-1:0]          elem;
  logic signed [2*W-1:0] elem_sq;
  logic [CNT_W-1:0]      eff_len;
  logic                  is_last;
  logic                  out_free;
  logic                  ram_we;
  logic                  ram_re;
  logic [W-1:0]          ram_rdata;
  logic                  scl_start;
  scl_stat_t             scl_stat;
  logic [W-1:0]          scl_result;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign is_push  = in_acc && (s_axis_tuser == OP_PUSH);
  assign is_pull  = in_acc && (s_axis_tuser == OP_PULL);
  assign elem     = s_axis_tdata[W-1:0];
  assign elem_sq  = $signed(elem) * $signed(elem);
  assign out_free = !m_valid_q || m_axis_tready;

  // effective length: zero counts as one, beyond the store as the store size
  always_comb begin
    if (len_q == '0) begin
      eff_len = CNT_W'(1);
    end else if (32'(len_q) > 32'(MAX_DIM)) begin
      eff_len = CNT_W'(MAX_DIM);
    end else begin
      eff_len = CNT_W'(len_q);
    end
  end

  assign is_last = ({1'b0, read_cnt_q} + {{CNT_W{1'b0}}, 1'b1}) >= {1'b0, load_cnt_q};

  // element store
  assign ram_we = is_push && !readout_q;
  assign ram_re = is_pull && readout_q;

  l2vn_ram #(
    .WIDTH (W),
    .DEPTH (MAX_DIM)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i (elem),
    .re_i    (ram_re),
    .raddr_i (read_cnt_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // scaler for one element
  assign scl_start = (st_q == ST_RD) && scale_q;

  l2vn_scaler #(
    .ELEM_WIDTH (W),
    .SUM_W      (SUM_W)
  ) u_scaler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scl_start),
    .elem_i   (ram_rdata),
    .sum_i    (sum_q),
    .stat_o   (scl_stat),
    .result_o (scl_result)
  );

  // controller
  always_comb begin
    st_d       = st_q;
    load_cnt_d = load_cnt_q;
    read_cnt_d = read_cnt_q;
    readout_d  = readout_q;
    scale_d    = scale_q;
    sum_d      = sum_q;
    sq_d       = sq_q;
    res_d      = res_q;
    last_d     = last_q;
    stat_d     = stat_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;
    m_last_d   = m_last_q;
    m_stat_d   = m_stat_q;

    // output register drains independently
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (st_q)
      ST_IDLE: begin
        if (is_push && !readout_q) begin
          sq_d       = unsigned'(elem_sq);
          load_cnt_d = load_cnt_q + 1'b1;
          st_d       = ST_ACC;
        end else if (is_pull) begin
          if (readout_q) begin
            last_d = is_last;
            stat_d = STATUS_OK;
            st_d   = ST_RD;
          end else begin
            res_d  = '0;
            last_d = 1'b0;
            stat_d = STATUS_NOT_READY;
            st_d   = ST_DONE;
          end
        end
      end
      ST_ACC: begin
        sum_d = sum_q + SUM_W'(sq_q);
        if (load_cnt_q >= eff_len) begin
          readout_d  = 1'b1;
          read_cnt_d = '0;
          scale_d    = en_q && (sum_d != '0);
        end
        st_d = ST_IDLE;
      end
      ST_RD: begin
        if (scale_q) begin
          st_d = ST_WAIT;
        end else begin
          res_d = ram_rdata;
          st_d  = ST_DONE;
        end
      end
      ST_WAIT: begin
        if (scl_stat.done) begin
          res_d = scl_result;
          st_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = res_q;
          m_last_d  = last_q;
          m_stat_d  = stat_q;
          if (stat_q == STATUS_OK) begin
            if (last_q) begin
              readout_d  = 1'b0;
              load_cnt_d = '0;
              read_cnt_d = '0;
              sum_d      = '0;
              scale_d    = 1'b0;
            end else begin
              read_cnt_d = read_cnt_q + 1'b1;
            end
          end
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  // control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      en_q       <= ENABLE_RESET;
      len_q      <= LENGTH_RESET;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      readout_q  <= 1'b0;
      scale_q    <= 1'b0;
      sum_q      <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      load_cnt_q <= load_cnt_d;
      read_cnt_q <= read_cnt_d;
      readout_q  <= readout_d;
      scale_q    <= scale_d;
      sum_q      <= sum_d;
      m_valid_q  <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ENABLE: en_q  <= cfg_data_i[0];
          REG_LENGTH: len_q <= cfg_data_i;
          default:    len_q <= len_q;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sq_q     <= sq_d;
    res_q    <= res_d;
    last_q   <= last_d;
    stat_q   <= stat_d;
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_stat_q <= m_stat_d;
  end

  // ports
  assign s_axis_tready = (st_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = DATA_W'(m_data_q);
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_stat_q;

  // checks
  `L2VN_ASSERT_NXT(a_last_ends_readout,
    (st_q == ST_DONE) && out_free && last_q && (stat_q == STATUS_OK),
    !readout_q && (load_cnt_q == '0) && (sum_q == '0),
    "last word did not return to loading")
  `L2VN_ASSERT_IMP(a_read_within_load,
    readout_q, read_cnt_q < load_cnt_q,
    "read position beyond loaded elements")
  `L2VN_ASSERT_IMP(a_not_ready_word,
    m_valid_q && (m_stat_q == STATUS_NOT_READY), (m_data_q == '0) && !m_last_q,
    "not-ready word carries data")
  `L2VN_ASSERT_IMP(a_scaler_idle_when_ready,
    st_q == ST_IDLE, !scl_stat.busy,
    "scaler busy while taking a new word")

endmodule

`default_nettype wire
